### hw/rtl/itpc_pkg.sv
`default_nettype none

package itpc_pkg;

  localparam int unsigned STACK_DEPTH = 32;

  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_STAR  = 8'h2A;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_LPAR  = 8'h28;
  localparam logic [7:0] CH_RPAR  = 8'h29;
  localparam logic [7:0] CH_LO_A  = 8'h61;
  localparam logic [7:0] CH_LO_Z  = 8'h7A;
  localparam logic [7:0] CH_UP_A  = 8'h41;
  localparam logic [7:0] CH_UP_Z  = 8'h5A;

  localparam logic [1:0] ERR_NONE      = 2'd0;
  localparam logic [1:0] ERR_OVERFLOW  = 2'd1;
  localparam logic [1:0] ERR_UNMATCHED = 2'd2;

  typedef struct packed {
    logic [7:0] symbol;
    logic       end_of_expression;
  } itpc_req_t;

  typedef struct packed {
    logic [7:0] out_symbol;
    logic [1:0] error_code;
    logic       last_of_run;
  } itpc_res_t;

  typedef enum logic [1:0] {
    OP_HOLD,
    OP_PUSH,
    OP_POP
  } itpc_cell_op_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MAIN,
    ST_FLUSH
  } itpc_state_e;

  function automatic logic is_letter(logic [7:0] ch);
    return ((ch >= CH_LO_A) && (ch <= CH_LO_Z)) || ((ch >= CH_UP_A) && (ch <= CH_UP_Z));
  endfunction

  function automatic logic [1:0] prio_of(logic [7:0] ch);
    logic [1:0] p;
    p = 2'd0;
    if ((ch == CH_STAR) || (ch == CH_SLASH)) begin
      p = 2'd2;
    end else if ((ch == CH_PLUS) || (ch == CH_MINUS)) begin
      p = 2'd1;
    end
    return p;
  endfunction

endpackage

`default_nettype wire

### hw/rtl/itpc_cell.sv
`default_nettype none

module itpc_cell (
  input  wire                     clk_i,
  input  itpc_pkg::itpc_cell_op_e op_i,
  input  wire  [7:0]              push_data_i,
  input  wire  [7:0]              pop_data_i,
  output logic [7:0]              data_o
);
  import itpc_pkg::*;

  logic [7:0] data_q, data_d;

  always_comb begin
    unique case (op_i)
      OP_PUSH: data_d = push_data_i;
      OP_POP:  data_d = pop_data_i;
      default: data_d = data_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign data_o = data_q;

endmodule

`default_nettype wire

### hw/rtl/infix_to_postfix_converter_unit.sv
// channel   direction  handshake                payload
// request   in         in_valid_i / in_ready_o  in_req_i  (symbol, end_of_expression)
// result    out        out_valid_o / out_ready_i out_res_o (out_symbol, error_code, last_of_run)
//
// one request at a time: ST_IDLE takes it, then ST_MAIN and ST_FLUSH step once
// for each emitted result, push or discarded '(' in the operator stack, and the
// unit takes no new request before the last of these steps.
// the stack is a row of shift cells with the top in cell 0, one push or pop per cycle when not stalled.
// a full result register stalls the sequencer until out_ready_i takes it.
// rst_ni clears the sequencer, the fill count and the result valid flag; cell data and result data are not reset.
`default_nettype none

module infix_to_postfix_converter_unit #(
  parameter int unsigned StackDepth = itpc_pkg::STACK_DEPTH
) (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  wire                  in_valid_i,
  output logic                 in_ready_o,
  input  itpc_pkg::itpc_req_t  in_req_i,
  output logic                 out_valid_o,
  input  wire                  out_ready_i,
  output itpc_pkg::itpc_res_t  out_res_o
);
  import itpc_pkg::*;

  localparam int unsigned CntW = $clog2(StackDepth + 1);

  itpc_state_e   state_q, state_d;
  logic [7:0]    sym_q, sym_d;
  logic          flush_q, flush_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic          out_valid_q, out_valid_d;
  itpc_res_t     out_q, out_d;
  itpc_cell_op_e cell_op;
  logic          emit;
  itpc_res_t     res;
  logic [7:0]    cell_data [StackDepth];
  logic [7:0]    top_sym, nxt_sym;
  logic          empty, full, can_emit;

  for (genvar i = 0; i < StackDepth; i++) begin : g_cell
    logic [7:0] push_src, pop_src;
    if (i == 0) begin : g_first
      assign push_src = sym_q;
    end else begin : g_mid
      assign push_src = cell_data[i-1];
    end
    if (i == StackDepth - 1) begin : g_last
      assign pop_src = '0;
    end else begin : g_rest
      assign pop_src = cell_data[i+1];
    end
    itpc_cell u_cell (
      .clk_i       (clk_i),
      .op_i        (cell_op),
      .push_data_i (push_src),
      .pop_data_i  (pop_src),
      .data_o      (cell_data[i])
    );
  end

  assign top_sym  = cell_data[0];
  assign nxt_sym  = cell_data[1];
  assign empty    = (cnt_q == '0);
  assign full     = (cnt_q == CntW'(StackDepth));
  assign can_emit = !out_valid_q || out_ready_i;

  always_comb begin
    state_d = state_q;
    sym_d   = sym_q;
    flush_d = flush_q;
    cnt_d   = cnt_q;
    cell_op = OP_HOLD;
    emit    = 1'b0;
    res     = '{out_symbol: top_sym, error_code: ERR_NONE, last_of_run: 1'b0};
    in_ready_o = 1'b0;

    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          sym_d   = in_req_i.symbol;
          flush_d = in_req_i.end_of_expression;
          state_d = ST_MAIN;
        end
      end
      ST_MAIN: begin
        if (can_emit) begin
          priority if (is_letter(sym_q)) begin
            emit            = 1'b1;
            res.out_symbol  = sym_q;
            res.last_of_run = !(flush_q && !empty);
            state_d         = (flush_q && !empty) ? ST_FLUSH : ST_IDLE;
          end else if (sym_q == CH_RPAR) begin
            if (empty) begin
              emit            = 1'b1;
              res.out_symbol  = '0;
              res.error_code  = ERR_UNMATCHED;
              res.last_of_run = 1'b1;
              state_d         = ST_IDLE;
            end else if (top_sym == CH_LPAR) begin
              // matching '(' is dropped without a result
              cell_op = OP_POP;
              cnt_d   = cnt_q - 1'b1;
              state_d = (flush_q && (cnt_q > CntW'(1))) ? ST_FLUSH : ST_IDLE;
            end else begin
              emit            = 1'b1;
              cell_op         = OP_POP;
              cnt_d           = cnt_q - 1'b1;
              res.last_of_run = (cnt_q > CntW'(1)) && (nxt_sym == CH_LPAR) &&
                                !(flush_q && (cnt_q > CntW'(2)));
            end
          end else if ((sym_q != CH_LPAR) && !empty &&
                       (prio_of(top_sym) >= prio_of(sym_q))) begin
            // a push always follows, so only a run without flush can end here
            emit            = 1'b1;
            cell_op         = OP_POP;
            cnt_d           = cnt_q - 1'b1;
            res.last_of_run = !flush_q &&
                              !((cnt_q > CntW'(1)) && (prio_of(nxt_sym) >= prio_of(sym_q)));
          end else if (full) begin
            cnt_d           = '0;
            emit            = 1'b1;
            res.out_symbol  = '0;
            res.error_code  = ERR_OVERFLOW;
            res.last_of_run = 1'b1;
            state_d         = ST_IDLE;
          end else begin
            cell_op = OP_PUSH;
            cnt_d   = cnt_q + 1'b1;
            state_d = flush_q ? ST_FLUSH : ST_IDLE;
          end
        end
      end
      ST_FLUSH: begin
        if (empty) begin
          state_d = ST_IDLE;
        end else if (can_emit) begin
          emit            = 1'b1;
          cell_op         = OP_POP;
          cnt_d           = cnt_q - 1'b1;
          res.last_of_run = (cnt_q == CntW'(1));
          if (cnt_q == CntW'(1)) begin
            state_d = ST_IDLE;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    out_d       = out_q;
    if (emit) begin
      out_valid_d = 1'b1;
      out_d       = res;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sym_q   <= sym_d;
    flush_q <= flush_d;
    out_q   <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_res_o   = out_q;

endmodule

`default_nettype wire

### hw/rtl/itpc_checker.sv
`default_nettype none

module itpc_checker (
  input wire                 clk_i,
  input wire                 rst_ni,
  input wire                 in_valid_i,
  input wire                 in_ready_o,
  input itpc_pkg::itpc_req_t in_req_i,
  input wire                 out_valid_o,
  input wire                 out_ready_i,
  input itpc_pkg::itpc_res_t out_res_o
);
  import itpc_pkg::*;

  // a held result must not change
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_res_o))
    else $error("result changed while stalled");

  // one request at a time: no second request right after one is taken
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("request taken in back-to-back cycles");

  // an error result carries no symbol and ends its run
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_res_o.error_code != ERR_NONE) |->
      (out_res_o.out_symbol == 8'd0) && out_res_o.last_of_run)
    else $error("malformed error result");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_res_o.error_code == ERR_NONE) ||
      (out_res_o.error_code == ERR_OVERFLOW) || (out_res_o.error_code == ERR_UNMATCHED))
    else $error("unknown error code");

endmodule

bind infix_to_postfix_converter_unit itpc_checker u_itpc_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .in_req_i    (in_req_i),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_res_o   (out_res_o)
);

`default_nettype wire
